### src/tbt_pkg.sv
// ----------------------------------------------------------------------------
// tbt_pkg
// Shared types and constants of the thermistor beta temperature converter.
// ----------------------------------------------------------------------------
package tbt_pkg;

    localparam int RD_W    = 13;   // millivolt reading and supply
    localparam int DIV_W   = 20;   // divider and nominal resistance
    localparam int BETA_W  = 14;
    localparam int CFG_W   = 20;   // widest configuration register
    localparam int IDX_W   = 8;
    localparam int NUM_W   = 33;   // resistance products
    localparam int LOG_W   = 6;    // index of the top set bit
    localparam int MANT_W  = 31;   // Q1.30 mantissa
    localparam int FRAC_N  = 20;   // log2 fraction bits
    localparam int ACC_W   = LOG_W + FRAC_N;
    localparam int LN_W    = 22;   // ln in Q6.16, unsigned magnitude
    localparam int Q1_W    = 38;   // first quotient and its dividend
    localparam int REM1_W  = BETA_W;
    localparam int INV_W   = 39;   // 1/T in Q7.32
    localparam int DEN2_W  = 40;   // 100 * 2^32 plus rounding
    localparam int Q2_W    = 17;   // kelvin in hundredths
    localparam int TEMP_W  = 16;

    localparam logic [23:0]       INV_T0_Q32   = 24'd14405391;
    localparam logic [31:0]       LN2_Q32      = 32'd2977044472;
    localparam logic [DEN2_W-1:0] KC_DIVIDEND  = 40'd429496729600;
    localparam logic [Q2_W-1:0]   KELVIN_OFF   = 17'd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd32767;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd27315;

    typedef enum logic [IDX_W-1:0] {
        REG_SUPPLY  = 8'd0,
        REG_DIVIDER = 8'd1,
        REG_NOMINAL = 8'd2,
        REG_BETA    = 8'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_HIGH = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    // Outcome class set by the range checks, updated by later stages and carried with the word.
    typedef enum logic [2:0] {
        K_OK,
        K_ZERO,
        K_HIGH,
        K_SAT_HI,
        K_SAT_LO
    } kind_t;

endpackage

### src/thermistor_beta_temperature_top.sv
// Throughput: one sample per cycle while the skid entry is empty; the two restoring
// dividers (38 and 17 stages) and the twenty log squaring stages are fully pipelined.
// A two-entry output register plus skid lets input continue while a result waits.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the register
// defaults: supply 3300 mV, divider 10000 ohm, nominal 100000 ohm, beta 3900 K.
// ----------------------------------------------------------------------------
// thermistor_beta_temperature_top
// NTC thermistor divider reading to Celsius via the beta equation.
// ----------------------------------------------------------------------------
module thermistor_beta_temperature_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // [12:0] read_mv
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,  // [15:0] temp_centi_c, [17:16] status
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tbt_pkg::IDX_W-1:0]   cfg_index,
    input  logic [tbt_pkg::CFG_W-1:0]   cfg_data
);
    import tbt_pkg::*;

    localparam int LN_LAT = FRAC_N + 3;

    logic [RD_W-1:0]   supply_reg;
    logic [DIV_W-1:0]  divider_reg;
    logic [DIV_W-1:0]  nominal_reg;
    logic [BETA_W-1:0] beta_reg;
    logic [BETA_W-1:0] beta_eff;
    logic              en;

    assign cfg_ready = 1'b1;
    assign beta_eff  = (beta_reg == '0) ? BETA_W'(1) : beta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg  <= 13'd3300;
            divider_reg <= 20'd10000;
            nominal_reg <= 20'd100000;
            beta_reg    <= 14'd3900;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SUPPLY:  supply_reg  <= cfg_data[RD_W-1:0];
                REG_DIVIDER: divider_reg <= cfg_data[DIV_W-1:0];
                REG_NOMINAL: nominal_reg <= cfg_data[DIV_W-1:0];
                REG_BETA:    beta_reg    <= cfg_data[BETA_W-1:0];
                default:     ;
            endcase
        end
    end

    // ---------------- stage 1: range checks ----------------
    logic            s1_v_reg;
    kind_t           s1_kind_reg;
    logic [RD_W-1:0] s1_rd_reg;
    logic [RD_W-1:0] s1_diff_reg;
    logic [RD_W-1:0] in_rd;

    assign in_rd         = s_axis_tdata[RD_W-1:0];
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_rd_reg   <= in_rd;
            s1_diff_reg <= supply_reg - in_rd;
            if (in_rd == '0)
            begin
                s1_kind_reg <= K_ZERO;
            end
            else if (in_rd >= supply_reg)
            begin
                s1_kind_reg <= K_HIGH;
            end
            else
            begin
                s1_kind_reg <= K_OK;
            end
        end
    end

    // ---------------- stage 2: resistance products ----------------
    logic             s2_v_reg;
    kind_t            s2_kind_reg;
    logic [NUM_W-1:0] s2_num_reg;
    logic [NUM_W-1:0] s2_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_num_reg <= NUM_W'(divider_reg) * NUM_W'(s1_diff_reg);
            s2_den_reg <= NUM_W'(s1_rd_reg) * NUM_W'(nominal_reg);
            // With a valid reading the difference is nonzero, so a zero product
            // comes only from a zero resistor register.
            if (s1_kind_reg == K_OK && divider_reg == '0)
            begin
                s2_kind_reg <= K_SAT_HI;
            end
            else if (s1_kind_reg == K_OK && nominal_reg == '0)
            begin
                s2_kind_reg <= K_SAT_LO;
            end
            else
            begin
                s2_kind_reg <= s1_kind_reg;
            end
        end
    end

    // ---------------- logarithms ----------------
    logic [LN_W-1:0] ln_num;
    logic [LN_W-1:0] ln_den;
    logic            ld_v_reg    [0:LN_LAT-1];
    kind_t           ld_kind_reg [0:LN_LAT-1];

    tbt_ln u_ln_num
    (
        .clk (clk),
        .en  (en),
        .n   (s2_num_reg),
        .ln  (ln_num)
    );

    tbt_ln u_ln_den
    (
        .clk (clk),
        .en  (en),
        .n   (s2_den_reg),
        .ln  (ln_den)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LN_LAT; i++)
            begin
                ld_v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            ld_v_reg[0] <= s2_v_reg;
            for (int i = 1; i < LN_LAT; i++)
            begin
                ld_v_reg[i] <= ld_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ld_kind_reg[0] <= s2_kind_reg;
            for (int i = 1; i < LN_LAT; i++)
            begin
                ld_kind_reg[i] <= ld_kind_reg[i-1];
            end
        end
    end

    // ---------------- log ratio, sign and magnitude ----------------
    logic              la_v_reg;
    kind_t             la_kind_reg;
    logic              la_neg_reg;
    logic [LN_W-1:0]   la_mag_reg;
    logic signed [LN_W:0] lnd;

    assign lnd = $signed({1'b0, ln_num}) - $signed({1'b0, ln_den});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_v_reg <= 1'b0;
        end
        else if (en)
        begin
            la_v_reg <= ld_v_reg[LN_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            la_kind_reg <= ld_kind_reg[LN_LAT-1];
            la_neg_reg  <= lnd[LN_W];
            la_mag_reg  <= lnd[LN_W] ? LN_W'(-lnd) : LN_W'(lnd);
        end
    end

    // ---------------- divide by beta, one quotient bit per stage ----------------
    logic              d1_v_reg    [0:Q1_W];
    kind_t             d1_kind_reg [0:Q1_W];
    logic              d1_neg_reg  [0:Q1_W];
    logic [Q1_W-1:0]   d1_w_reg    [0:Q1_W];
    logic [REM1_W-1:0] d1_r_reg    [0:Q1_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Q1_W; i++)
            begin
                d1_v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            d1_v_reg[0] <= la_v_reg;
            for (int i = 1; i <= Q1_W; i++)
            begin
                d1_v_reg[i] <= d1_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_kind_reg[0] <= la_kind_reg;
            d1_neg_reg[0]  <= la_neg_reg;
            d1_w_reg[0]    <= {la_mag_reg, 16'd0} + Q1_W'(beta_eff >> 1);
            d1_r_reg[0]    <= '0;
        end
    end

    for (genvar g = 0; g < Q1_W; g++)
    begin : g_div1
        logic [REM1_W:0] rt;
        logic            ge;
        assign rt = {d1_r_reg[g], d1_w_reg[g][Q1_W-1]};
        assign ge = rt >= {1'b0, beta_eff};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d1_kind_reg[g+1] <= d1_kind_reg[g];
                d1_neg_reg[g+1]  <= d1_neg_reg[g];
                d1_w_reg[g+1]    <= {d1_w_reg[g][Q1_W-2:0], ge};
                d1_r_reg[g+1]    <= ge ? REM1_W'(rt - {1'b0, beta_eff}) : REM1_W'(rt);
            end
        end
    end

    // ---------------- 1/T ----------------
    logic                   e1_v_reg;
    kind_t                  e1_kind_reg;
    logic [INV_W-1:0]       e1_inv_reg;
    logic signed [INV_W:0]  inv;

    assign inv = d1_neg_reg[Q1_W]
               ? $signed((INV_W+1)'(INV_T0_Q32)) - $signed((INV_W+1)'(d1_w_reg[Q1_W]))
               : $signed((INV_W+1)'(INV_T0_Q32)) + $signed((INV_W+1)'(d1_w_reg[Q1_W]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e1_v_reg <= d1_v_reg[Q1_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_inv_reg <= inv[INV_W-1:0];
            if (d1_kind_reg[Q1_W] == K_OK && (inv[INV_W] || inv == '0))
            begin
                e1_kind_reg <= K_SAT_HI;
            end
            else
            begin
                e1_kind_reg <= d1_kind_reg[Q1_W];
            end
        end
    end

    // ---------------- reciprocal, 17 quotient bits ----------------
    logic [DEN2_W-1:0] kc_num;
    logic              kc_ovf;
    logic              d2_v_reg    [0:Q2_W];
    kind_t             d2_kind_reg [0:Q2_W];
    logic [INV_W-1:0]  d2_inv_reg  [0:Q2_W];
    logic [Q2_W-1:0]   d2_w_reg    [0:Q2_W];
    logic [INV_W-1:0]  d2_r_reg    [0:Q2_W];

    assign kc_num = KC_DIVIDEND + DEN2_W'(e1_inv_reg >> 1);
    // A quotient of 2^17 or more is far above the temperature range.
    assign kc_ovf = INV_W'(kc_num[DEN2_W-1:Q2_W]) >= e1_inv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= Q2_W; i++)
            begin
                d2_v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            d2_v_reg[0] <= e1_v_reg;
            for (int i = 1; i <= Q2_W; i++)
            begin
                d2_v_reg[i] <= d2_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_kind_reg[0] <= (e1_kind_reg == K_OK && kc_ovf) ? K_SAT_HI : e1_kind_reg;
            d2_inv_reg[0]  <= e1_inv_reg;
            d2_w_reg[0]    <= kc_num[Q2_W-1:0];
            d2_r_reg[0]    <= INV_W'(kc_num[DEN2_W-1:Q2_W]);
        end
    end

    for (genvar g = 0; g < Q2_W; g++)
    begin : g_div2
        logic [INV_W:0] rt;
        logic           ge;
        assign rt = {d2_r_reg[g], d2_w_reg[g][Q2_W-1]};
        assign ge = rt >= {1'b0, d2_inv_reg[g]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d2_kind_reg[g+1] <= d2_kind_reg[g];
                d2_inv_reg[g+1]  <= d2_inv_reg[g];
                d2_w_reg[g+1]    <= {d2_w_reg[g][Q2_W-2:0], ge};
                d2_r_reg[g+1]    <= ge ? INV_W'(rt - {1'b0, d2_inv_reg[g]}) : INV_W'(rt);
            end
        end
    end

    // ---------------- Celsius, clamp, status ----------------
    logic                    f_v_reg;
    logic [23:0]             f_data_reg;
    logic signed [Q2_W:0]    tc;
    logic signed [TEMP_W-1:0] f_temp;
    status_t                 f_status;

    assign tc = $signed({1'b0, d2_w_reg[Q2_W]}) - $signed({1'b0, KELVIN_OFF});

    always_comb
    begin
        f_temp   = TEMP_MAX;
        f_status = ST_SAT;
        unique case (d2_kind_reg[Q2_W])
            K_ZERO:
            begin
                f_temp   = TEMP_MIN;
                f_status = ST_ZERO;
            end
            K_HIGH:
            begin
                f_temp   = TEMP_MAX;
                f_status = ST_HIGH;
            end
            K_SAT_HI:
            begin
                f_temp   = TEMP_MAX;
                f_status = ST_SAT;
            end
            K_SAT_LO:
            begin
                f_temp   = TEMP_MIN;
                f_status = ST_SAT;
            end
            K_OK:
            begin
                if (tc > (Q2_W+1)'(TEMP_MAX))
                begin
                    f_temp   = TEMP_MAX;
                    f_status = ST_SAT;
                end
                else if (tc < (Q2_W+1)'(TEMP_MIN))
                begin
                    f_temp   = TEMP_MIN;
                    f_status = ST_SAT;
                end
                else
                begin
                    f_temp   = TEMP_W'(tc);
                    f_status = ST_OK;
                end
            end
            default:
            begin
                f_temp   = TEMP_MAX;
                f_status = ST_SAT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
        end
        else if (en)
        begin
            f_v_reg <= d2_v_reg[Q2_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_data_reg <= {6'd0, f_status, f_temp};
        end
    end

    // ---------------- output register and skid ----------------
    logic        out_v_reg;
    logic [23:0] out_data_reg;
    logic        skid_v_reg;
    logic [23:0] skid_data_reg;

    assign en            = !skid_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (m_axis_tready)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (!out_v_reg || m_axis_tready)
        begin
            out_v_reg <= f_v_reg;
        end
        else if (f_v_reg)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (m_axis_tready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (!out_v_reg || m_axis_tready)
        begin
            out_data_reg <= f_data_reg;
        end
        else if (f_v_reg)
        begin
            skid_data_reg <= f_data_reg;
        end
    end

    // ---------------- assertions ----------------
    a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held without an output word");

    a_zero_is_cold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_data_reg[17:16] == ST_ZERO) |-> out_data_reg[15:0] == TEMP_MIN)
        else $error("zero reading must report the cold limit");

    a_high_is_hot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_data_reg[17:16] == ST_HIGH) |-> out_data_reg[15:0] == TEMP_MAX)
        else $error("reading at supply must report the hot limit");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |=> $stable(f_data_reg) || !skid_v_reg)
        else $error("pipeline moved while the skid entry was full");

endmodule

### src/tbt_ln.sv
// ----------------------------------------------------------------------------
// tbt_ln
// Pipelined natural logarithm of a 33-bit integer, Q6.16 result.
// Leading-one search, normalize, twenty squaring stages, scale by ln 2.
// ----------------------------------------------------------------------------
module tbt_ln
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [tbt_pkg::NUM_W-1:0]  n,
    output logic [tbt_pkg::LN_W-1:0]   ln
);
    import tbt_pkg::*;

    logic [NUM_W-1:0]  a_n_reg;
    logic [LOG_W-1:0]  a_k_reg;
    logic [LOG_W-1:0]  a_k_next;
    logic [NUM_W-1:0]  norm;
    logic [MANT_W-1:0] m_reg   [0:FRAC_N];
    logic [ACC_W-1:0]  acc_reg [0:FRAC_N];
    logic [LN_W-1:0]   ln_reg;
    logic [ACC_W+31:0] prod;

    always_comb
    begin
        a_k_next = '0;
        for (int i = 0; i < NUM_W; i++)
        begin
            if (n[i])
            begin
                a_k_next = LOG_W'(i);
            end
        end
    end

    // Top set bit lands on the word's MSB; the mantissa is its upper 31 bits.
    assign norm = a_n_reg << (LOG_W'(NUM_W - 1) - a_k_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_n_reg    <= n;
            a_k_reg    <= a_k_next;
            m_reg[0]   <= norm[NUM_W-1:NUM_W-MANT_W];
            acc_reg[0] <= {a_k_reg, FRAC_N'(0)};
        end
    end

    for (genvar g = 0; g < FRAC_N; g++)
    begin : g_sq
        logic [2*MANT_W-1:0] sq;
        logic [MANT_W:0]     m2;
        assign sq = m_reg[g] * m_reg[g];
        assign m2 = sq[2*MANT_W-1:MANT_W-1];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (m2[MANT_W])
                begin
                    m_reg[g+1]   <= m2[MANT_W:1];
                    acc_reg[g+1] <= acc_reg[g] | (ACC_W'(1) << (FRAC_N - 1 - g));
                end
                else
                begin
                    m_reg[g+1]   <= m2[MANT_W-1:0];
                    acc_reg[g+1] <= acc_reg[g];
                end
            end
        end
    end

    assign prod = (ACC_W+32)'(acc_reg[FRAC_N]) * (ACC_W+32)'(LN2_Q32)
                + ((ACC_W+32)'(1) << 35);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ln_reg <= prod[36+LN_W-1:36];
        end
    end

    assign ln = ln_reg;

endmodule

### verif/tb_thermistor_beta_temperature_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thermistor_beta_temperature_top
// Self-checking bench for the NTC beta-equation temperature converter.
// A directed sample table and then random samples go in under several register
// settings and stall patterns. Every result word is checked against a
// bit-exact fixed-point predictor or a given expectation.
// ----------------------------------------------------------------------------
module tb_thermistor_beta_temperature_top;
    import tbt_pkg::*;

    localparam int LATENCY = 86;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    // Predictor copy of the configuration registers.
    logic [12:0] supply_q;
    logic [19:0] divider_q;
    logic [19:0] nominal_q;
    logic [13:0] beta_q;

    typedef struct packed {
        logic signed [15:0] temp;
        status_t            status;
    } reading_t;

    reading_t pending_temps[$];
    int       errors;
    int       cycles;
    int       send_idle_pct;
    int       recv_stall_pct;

    thermistor_beta_temperature_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Natural log of n >= 1 in Q6.16, by squaring out the log2 fraction bits.
    function automatic longint unsigned ln_fixed(input longint unsigned n);
        int                k;
        longint unsigned   m;
        longint unsigned   acc;
        logic [127:0]      prod;
        k = 0;
        for (int i = 63; i >= 0; i--)
        begin
            if (n[i])
            begin
                k = i;
                break;
            end
        end
        m = (k >= 30) ? (n >> (k - 30)) : (n << (30 - k));
        acc = longint'(k) << 20;
        for (int i = 19; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                acc = acc | (64'd1 << i);
            end
        end
        prod = 128'(acc) * 128'(LN2_Q32) + (128'd1 << 35);
        return 64'(prod >> 36);
    endfunction

    function automatic reading_t convert_reading(input logic [12:0] rd);
        reading_t        r;
        longint unsigned num;
        longint unsigned den;
        longint unsigned beta;
        longint unsigned mag;
        longint unsigned term;
        longint          ln;
        longint          inv;
        longint          kc;
        longint          t;
        if (rd == 0)
            return '{TEMP_MIN, ST_ZERO};
        if (rd >= supply_q)
            return '{TEMP_MAX, ST_HIGH};
        num = 64'(divider_q) * 64'(supply_q - rd);
        den = 64'(rd) * 64'(nominal_q);
        if (num == 0)
            return '{TEMP_MAX, ST_SAT};
        if (den == 0)
            return '{TEMP_MIN, ST_SAT};
        ln = longint'(ln_fixed(num)) - longint'(ln_fixed(den));
        beta = (beta_q != 0) ? 64'(beta_q) : 64'd1;
        mag = 64'(ln < 0 ? -ln : ln) << 16;
        term = (mag + beta / 2) / beta;
        inv = longint'(INV_T0_Q32) + (ln < 0 ? -longint'(term) : longint'(term));
        if (inv <= 0)
            return '{TEMP_MAX, ST_SAT};
        kc = longint'((64'(KC_DIVIDEND) + 64'(inv) / 2) / 64'(inv));
        t = kc - 27315;
        if (t > 32767)
            return '{TEMP_MAX, ST_SAT};
        if (t < -27315)
            return '{TEMP_MIN, ST_SAT};
        r.temp = 16'(t);
        r.status = ST_OK;
        return r;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SUPPLY:  supply_q  = value[12:0];
            REG_DIVIDER: divider_q = value;
            REG_NOMINAL: nominal_q = value;
            REG_BETA:    beta_q    = value[13:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_temps.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // Registers change only once the pipeline is empty.
    task automatic load_settings(input logic [12:0] sup, input logic [19:0] dv,
                                 input logic [19:0] nom, input logic [13:0] bt);
        drain();
        write_reg(REG_SUPPLY, 20'(sup));
        write_reg(REG_DIVIDER, dv);
        write_reg(REG_NOMINAL, nom);
        write_reg(REG_BETA, 20'(bt));
    endtask

    // Sends one sample; a given expectation overrides the predictor.
    // The valid line stays high after a word so the next one can follow directly.
    task automatic send_sample(input logic [12:0] rd, input bit typed,
                               input reading_t typed_result);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, rd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_temps.push_back(typed ? typed_result : convert_reading(rd));
    endtask

    // Result word checker; the receiver stalls are drawn here as well.
    always @(posedge clk)
    begin
        reading_t exp_r;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_temps.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    exp_r = pending_temps.pop_front();
                    if (m_axis_tdata[15:0] !== exp_r.temp)
                    begin
                        $display("%0t: temp expected %0d actual %0d", $time, exp_r.temp,
                                 $signed(m_axis_tdata[15:0]));
                        errors++;
                    end
                    if (m_axis_tdata[17:16] !== exp_r.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_r.status, m_axis_tdata[17:16]);
                        errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    typedef struct {
        logic [12:0] rd;
        bit          typed;
        reading_t    result;
    } sample_row_t;

    // Directed rows under reset settings (3300 mV, 10k, 100k, 3900 K).
    sample_row_t directed_rows[] = '{
        '{13'd0,    1'b1, '{TEMP_MIN, ST_ZERO}},
        '{13'd3300, 1'b1, '{TEMP_MAX, ST_HIGH}},
        '{13'd8191, 1'b1, '{TEMP_MAX, ST_HIGH}},
        '{13'd5000, 1'b1, '{TEMP_MAX, ST_HIGH}},
        '{13'd1,    1'b0, '{16'sd0, ST_OK}},
        '{13'd3299, 1'b0, '{16'sd0, ST_OK}},
        '{13'd300,  1'b0, '{16'sd0, ST_OK}},
        '{13'd1650, 1'b0, '{16'sd0, ST_OK}},
        '{13'd2730, 1'b0, '{16'sd0, ST_OK}},
        '{13'd4096, 1'b1, '{TEMP_MAX, ST_HIGH}},
        '{13'd2047, 1'b0, '{16'sd0, ST_OK}},
        '{13'd1365, 1'b0, '{16'sd0, ST_OK}}
    };

    task automatic random_burst(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_sample(13'($urandom), 1'b0, '0);
            else
                send_sample(13'($urandom_range(supply_q)), 1'b0, '0);
        end
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        supply_q = 13'd3300;
        divider_q = 20'd10000;
        nominal_q = 20'd100000;
        beta_q = 14'd3900;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].rd, directed_rows[i].typed, directed_rows[i].result);
        drain();

        // Degenerate resistors, zero beta, zero supply, extreme settings and an out-of-range register index.
        load_settings(13'd5000, 20'd0, 20'd100000, 14'd0);
        write_reg(reg_idx_t'(8'd200), 20'hFFFFF);
        send_sample(13'd2500, 1'b1, '{TEMP_MAX, ST_SAT});
        send_sample(13'd4999, 1'b1, '{TEMP_MAX, ST_SAT});
        load_settings(13'd5000, 20'd10000, 20'd0, 14'd16383);
        send_sample(13'd1, 1'b1, '{TEMP_MIN, ST_SAT});
        send_sample(13'd2500, 1'b1, '{TEMP_MIN, ST_SAT});
        load_settings(13'd0, 20'd10000, 20'd10000, 14'd3900);
        send_sample(13'd7, 1'b1, '{TEMP_MAX, ST_HIGH});
        load_settings(13'd8191, 20'hFFFFF, 20'd1, 14'd1000);
        send_sample(13'd1, 1'b0, '0);
        send_sample(13'd8190, 1'b0, '0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            case (phase)
                0: load_settings(13'd3300, 20'd10000, 20'd100000, 14'd3900);
                1: load_settings(13'd1, 20'd1, 20'd1, 14'd1000);
                2: load_settings(13'd5000, 20'd1000000, 20'd1000000, 14'd10000);
                3: load_settings(13'd8191, 20'hFFFFF, 20'hFFFFF, 14'h3FFF);
                default: load_settings(13'($urandom_range(5000, 1)),
                                       20'($urandom_range(1000000, 1)),
                                       20'($urandom_range(1000000, 1)),
                                       14'($urandom_range(10000, 1000)));
            endcase
            random_burst(55);
            drain();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
